### sv/rbba_pkg.sv
package rbba_pkg;

    localparam int MAX_WIDTH        = 1024;
    localparam int MAX_HEIGHT       = 1024;
    localparam int MAX_BLOBS        = 4096;
    localparam int MAX_RUNS_PER_ROW = 512;

    localparam int COL_W      = 10;
    localparam int DIM_W      = 11;
    localparam int BLOB_W     = $clog2(MAX_BLOBS);
    localparam int BCNT_W     = BLOB_W + 1;
    localparam int RUN_AW     = $clog2(MAX_RUNS_PER_ROW);
    localparam int RCNT_W     = RUN_AW + 1;
    localparam int AREA_W     = 21;
    localparam int SUM_W      = 32;
    localparam int OSUM_W     = 20;
    localparam int RANK_W     = 4;
    localparam int RANK_MAX   = 15;
    localparam int DIV_CW     = $clog2(SUM_W);
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    localparam logic [DIM_W-1:0]  MAX_W_C   = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0]  MAX_H_C   = DIM_W'(MAX_HEIGHT);
    localparam logic [BCNT_W-1:0] BLOBS_C   = BCNT_W'(MAX_BLOBS);
    localparam logic [RCNT_W-1:0] RUNS_C    = RCNT_W'(MAX_RUNS_PER_ROW);

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_WOB    = 2'd2
    } reg_idx_t;

    typedef enum logic {
        ACT_PIXEL = 1'b0,
        ACT_READ  = 1'b1
    } action_t;

    typedef struct packed {
        logic       action;
        logic [7:0] pixel;
    } pix_in_t;

    typedef struct packed {
        logic              blob_valid;
        logic [COL_W-1:0]  box_left;
        logic [COL_W-1:0]  box_top;
        logic [COL_W-1:0]  box_right;
        logic [COL_W-1:0]  box_bottom;
        logic [AREA_W-1:0] blob_area;
        logic [COL_W-1:0]  centroid_col;
        logic [COL_W-1:0]  centroid_row;
        logic              end_of_list;
        logic              pool_overflow;
    } blob_out_t;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [COL_W-1:0]  left;
        logic [COL_W-1:0]  bottom;
        logic [COL_W-1:0]  right;
        logic [COL_W-1:0]  top;
        logic [AREA_W-1:0] area;
        logic [SUM_W-1:0]  csum;
        logic [SUM_W-1:0]  rsum;
    } rec_t;

    typedef struct packed {
        logic [COL_W-1:0]  rstart;
        logic [COL_W-1:0]  rstop;
        logic [BLOB_W-1:0] blob;
    } run_t;

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [COL_W-1:0]  row;
        logic [COL_W-1:0]  open_start;
        logic [OSUM_W-1:0] open_sum;
        logic              run_open;
        logic              frame_done;
        logic [RCNT_W-1:0] prev_cnt;
        logic [RCNT_W-1:0] cur_cnt;
        logic              bank;
        logic [BCNT_W-1:0] created;
        logic [BCNT_W-1:0] readout;
        logic              ovf;
    } frame_t;

endpackage

### sv/run_based_blob_analysis_core.sv
// channel  | direction | signals                          | payload
// ---------+-----------+----------------------------------+-----------------------------
// input    | in        | in_valid / in_ready              | in_data  (pix_in_t)
// output   | out       | out_valid / out_ready            | out_data (blob_out_t)
// config   | in        | psel penable pwrite paddr pwdata | prdata, pready tied high
//
// A pixel that closes no run is handled in S_IDLE alone; a closing run passes S_SCAN_RD
// and S_SCAN_CHK per previous-row run it is checked against, S_FIND_RD and S_FIND_CHK
// per union-find parent step and S_JOIN, S_MRG_A, S_MRG_B per merge, all on the parent,
// record and run memories. A read walks the parent memory blob by blob, then runs a
// 32-step shared divider twice; the result waits in an output register.
// Reset clears control state only; memories are written before they are read.
// in_ready is low while an item is in work; pixels keep flowing while one result waits
// in the output register, and a second read holds until that result leaves.
module run_based_blob_analysis_core
    import rbba_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  pix_in_t            in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output blob_out_t          out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    typedef enum logic [16:0] {
        S_IDLE     = 17'h00001,
        S_SCAN_RD  = 17'h00002,
        S_SCAN_CHK = 17'h00004,
        S_FIND_RD  = 17'h00008,
        S_FIND_CHK = 17'h00010,
        S_JOIN     = 17'h00020,
        S_UPD      = 17'h00040,
        S_MRG_A    = 17'h00080,
        S_MRG_B    = 17'h00100,
        S_STORE    = 17'h00200,
        S_RD_SCAN  = 17'h00400,
        S_RD_CHK   = 17'h00800,
        S_RD_NXT   = 17'h01000,
        S_RD_NCHK  = 17'h02000,
        S_DIV_LD   = 17'h04000,
        S_DIV      = 17'h08000,
        S_OUT      = 17'h10000
    } state_t;

    typedef struct packed {
        logic [COL_W-1:0]  cstart;
        logic [COL_W-1:0]  cstop;
        logic [OSUM_W-1:0] csum;
        logic [COL_W-1:0]  y;
        logic              eol;
        logic [RCNT_W-1:0] idx;
        logic              has;
        logic [BLOB_W-1:0] cur;
        logic [BLOB_W-1:0] node;
    } clo_t;

    state_t           state_reg, state_next;
    frame_t           frm_reg, frm_next;
    clo_t             clo_reg, clo_next;
    logic [DIM_W-1:0] width_reg, height_reg;
    logic             wob_reg;
    logic             out_valid_reg, out_valid_next;
    blob_out_t        out_reg, out_next;
    blob_out_t        res_reg, res_next;
    rec_t             arec_reg, arec_next;
    logic [SUM_W-1:0] prod_reg, prod_next;
    logic [BCNT_W-1:0] k_reg, k_next, nxt_reg, nxt_next;
    logic             last_reg, last_next;
    logic [AREA_W-1:0] div_rem_reg, div_rem_next, div_d_reg, div_d_next;
    logic [SUM_W-1:0] div_q_reg, div_q_next;
    logic [DIV_CW-1:0] div_cnt_reg, div_cnt_next;
    logic             div_y_reg, div_y_next;

    logic [DIM_W-1:0] eff_w, eff_h;
    logic             cfg_wr;

    logic                          run_we, run_re;
    logic [RUN_AW:0]               run_waddr, run_raddr;
    run_t                          run_wdata, run_rdata;
    logic                          par_we, par_re;
    logic [BLOB_W-1:0]             par_waddr, par_raddr, par_wdata, par_rdata;
    logic                          rec_we, rec_re;
    logic [BLOB_W-1:0]             rec_waddr, rec_raddr;
    rec_t                          rec_wdata, rec_rdata;

    logic signed [DIM_W:0]   flip_s;
    logic signed [DIM_W:0]   len_s;
    logic signed [2*DIM_W+1:0] prod_s;

    rbba_ram #(.WIDTH($bits(run_t)), .DEPTH(2 * MAX_RUNS_PER_ROW)) u_run_ram (
        .clk   (clk),
        .we    (run_we),
        .waddr (run_waddr),
        .wdata (run_wdata),
        .re    (run_re),
        .raddr (run_raddr),
        .rdata (run_rdata)
    );

    rbba_ram #(.WIDTH(BLOB_W), .DEPTH(MAX_BLOBS)) u_par_ram (
        .clk   (clk),
        .we    (par_we),
        .waddr (par_waddr),
        .wdata (par_wdata),
        .re    (par_re),
        .raddr (par_raddr),
        .rdata (par_rdata)
    );

    rbba_ram #(.WIDTH($bits(rec_t)), .DEPTH(MAX_BLOBS)) u_rec_ram (
        .clk   (clk),
        .we    (rec_we),
        .waddr (rec_waddr),
        .wdata (rec_wdata),
        .re    (rec_re),
        .raddr (rec_raddr),
        .rdata (rec_rdata)
    );

    assign eff_w = (width_reg == '0) ? DIM_W'(1) : (width_reg > MAX_W_C) ? MAX_W_C : width_reg;
    assign eff_h = (height_reg == '0) ? DIM_W'(1)
                 : (height_reg > MAX_H_C) ? MAX_H_C : height_reg;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_WIDTH:  prdata = PDATA_W'(width_reg);
            REG_HEIGHT: prdata = PDATA_W'(height_reg);
            REG_WOB:    prdata = PDATA_W'(wob_reg);
            default:    prdata = '0;
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign flip_s    = $signed({1'b0, eff_h}) - (DIM_W+1)'(1) - $signed({2'b0, clo_reg.y});
    assign len_s     = $signed({2'b0, clo_reg.cstop}) - $signed({2'b0, clo_reg.cstart})
                     + (DIM_W+1)'(1);
    assign prod_s    = flip_s * len_s;
    assign prod_next = SUM_W'(prod_s);

    function automatic frame_t row_end(frame_t fi, logic [DIM_W-1:0] h);
        frame_t           fo;
        logic [DIM_W-1:0] r1;
        fo          = fi;
        r1          = {1'b0, fi.row} + DIM_W'(1);
        fo.bank     = ~fi.bank;
        fo.prev_cnt = fi.cur_cnt;
        fo.cur_cnt  = '0;
        if (r1 >= h)
        begin
            fo.frame_done = 1'b1;
            fo.row        = '0;
            fo.prev_cnt   = '0;
        end
        else
        begin
            fo.row = r1[COL_W-1:0];
        end
        return fo;
    endfunction

    always_comb
    begin
        frame_t            f;
        clo_t              c;
        rec_t              a;
        rec_t              b;
        rec_t              nr;
        logic [COL_W-1:0]  x;
        logic              fg;
        logic              lastcol;
        logic [OSUM_W-1:0] sv;
        logic [BLOB_W-1:0] cv;
        logic              stored;
        logic [DIM_W-1:0]  e1;
        logic [AREA_W:0]   rsh;
        logic [SUM_W-1:0]  qn;

        f              = frm_reg;
        c              = clo_reg;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        res_next       = res_reg;
        arec_next      = arec_reg;
        k_next         = k_reg;
        nxt_next       = nxt_reg;
        last_next      = last_reg;
        div_rem_next   = div_rem_reg;
        div_d_next     = div_d_reg;
        div_q_next     = div_q_reg;
        div_cnt_next   = div_cnt_reg;
        div_y_next     = div_y_reg;
        run_we         = 1'b0;
        run_waddr      = {frm_reg.bank, frm_reg.cur_cnt[RUN_AW-1:0]};
        run_wdata      = '0;
        run_re         = 1'b0;
        run_raddr      = {~frm_reg.bank, clo_reg.idx[RUN_AW-1:0]};
        par_we         = 1'b0;
        par_waddr      = '0;
        par_wdata      = '0;
        par_re         = 1'b0;
        par_raddr      = clo_reg.node;
        rec_we         = 1'b0;
        rec_waddr      = '0;
        rec_wdata      = '0;
        rec_re         = 1'b0;
        rec_raddr      = clo_reg.node;
        a              = arec_reg;
        b              = rec_rdata;
        nr             = rec_rdata;
        x              = '0;
        fg             = 1'b0;
        lastcol        = 1'b0;
        sv             = '0;
        cv             = '0;
        stored         = 1'b0;
        e1             = {1'b0, clo_reg.cstop} + DIM_W'(1);
        rsh            = {div_rem_reg, div_q_reg[SUM_W-1]};
        qn             = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.action == ACT_PIXEL)
                    begin
                        if (f.frame_done)
                        begin
                            f = '0;
                        end
                        x       = f.col;
                        fg      = in_data.pixel != {7'b0, ~wob_reg};
                        lastcol = ({1'b0, x} + DIM_W'(1)) >= eff_w;
                        c.y     = f.row;
                        c.idx   = '0;
                        c.has   = 1'b0;
                        c.eol   = lastcol;
                        state_next = S_IDLE;
                        if (fg)
                        begin
                            if (!f.run_open)
                            begin
                                f.open_start = x;
                                sv           = OSUM_W'(x);
                            end
                            else
                            begin
                                sv = f.open_sum + OSUM_W'(x);
                            end
                            f.open_sum = sv;
                            f.run_open = 1'b1;
                            if (lastcol)
                            begin
                                f.run_open = 1'b0;
                                c.cstart   = f.open_start;
                                c.cstop    = x;
                                c.csum     = sv;
                                state_next = S_SCAN_RD;
                            end
                        end
                        else if (f.run_open)
                        begin
                            f.run_open = 1'b0;
                            c.cstart   = f.open_start;
                            c.cstop    = x - COL_W'(1);
                            c.csum     = f.open_sum;
                            state_next = S_SCAN_RD;
                        end
                        f.col = lastcol ? '0 : x + COL_W'(1);
                        if (lastcol && state_next == S_IDLE)
                        begin
                            f = row_end(f, eff_h);
                        end
                    end
                    else
                    begin
                        k_next     = f.readout;
                        state_next = S_RD_SCAN;
                    end
                end
            end

            S_SCAN_RD:
            begin
                if (clo_reg.idx >= frm_reg.prev_cnt)
                begin
                    state_next = S_STORE;
                end
                else
                begin
                    run_re     = 1'b1;
                    state_next = S_SCAN_CHK;
                end
            end

            S_SCAN_CHK:
            begin
                if ({1'b0, run_rdata.rstart} > e1)
                begin
                    state_next = S_STORE;
                end
                else if ({1'b0, clo_reg.cstart} <= ({1'b0, run_rdata.rstop} + DIM_W'(1)))
                begin
                    c.node     = run_rdata.blob;
                    state_next = S_FIND_RD;
                end
                else
                begin
                    c.idx      = clo_reg.idx + RCNT_W'(1);
                    state_next = S_SCAN_RD;
                end
            end

            S_FIND_RD:
            begin
                par_re     = 1'b1;
                state_next = S_FIND_CHK;
            end

            S_FIND_CHK:
            begin
                if (par_rdata == clo_reg.node)
                begin
                    state_next = S_JOIN;
                end
                else
                begin
                    c.node     = par_rdata;
                    state_next = S_FIND_RD;
                end
            end

            S_JOIN:
            begin
                if (!clo_reg.has)
                begin
                    c.has      = 1'b1;
                    c.cur      = clo_reg.node;
                    rec_re     = 1'b1;
                    state_next = S_UPD;
                end
                else if (clo_reg.cur != clo_reg.node)
                begin
                    rec_re     = 1'b1;
                    rec_raddr  = clo_reg.cur;
                    state_next = S_MRG_A;
                end
                else
                begin
                    c.idx      = clo_reg.idx + RCNT_W'(1);
                    state_next = S_SCAN_RD;
                end
            end

            S_UPD:
            begin
                if (clo_reg.cstart < nr.left)
                begin
                    nr.left = clo_reg.cstart;
                end
                if (clo_reg.cstop > nr.right)
                begin
                    nr.right = clo_reg.cstop;
                end
                nr.top     = clo_reg.y;
                nr.area    = rec_rdata.area + AREA_W'(len_s);
                nr.csum    = rec_rdata.csum + SUM_W'(clo_reg.csum);
                nr.rsum    = rec_rdata.rsum + prod_reg;
                rec_we     = 1'b1;
                rec_waddr  = clo_reg.cur;
                rec_wdata  = nr;
                c.idx      = clo_reg.idx + RCNT_W'(1);
                state_next = S_SCAN_RD;
            end

            S_MRG_A:
            begin
                arec_next  = rec_rdata;
                rec_re     = 1'b1;
                state_next = S_MRG_B;
            end

            S_MRG_B:
            begin
                nr.left   = (a.left < b.left) ? a.left : b.left;
                nr.bottom = (a.bottom < b.bottom) ? a.bottom : b.bottom;
                nr.right  = (a.right > b.right) ? a.right : b.right;
                nr.top    = (a.top > b.top) ? a.top : b.top;
                nr.area   = a.area + b.area;
                nr.csum   = a.csum + b.csum;
                nr.rsum   = a.rsum + b.rsum;
                par_we    = 1'b1;
                rec_we    = 1'b1;
                if (a.rank > b.rank)
                begin
                    nr.rank   = a.rank;
                    par_waddr = clo_reg.node;
                    par_wdata = clo_reg.cur;
                    rec_waddr = clo_reg.cur;
                end
                else
                begin
                    nr.rank = b.rank;
                    if (a.rank == b.rank && b.rank < RANK_W'(RANK_MAX))
                    begin
                        nr.rank = b.rank + RANK_W'(1);
                    end
                    par_waddr = clo_reg.cur;
                    par_wdata = clo_reg.node;
                    rec_waddr = clo_reg.node;
                    c.cur     = clo_reg.node;
                end
                rec_wdata  = nr;
                c.idx      = clo_reg.idx + RCNT_W'(1);
                state_next = S_SCAN_RD;
            end

            S_STORE:
            begin
                stored = 1'b1;
                cv     = clo_reg.cur;
                if (!clo_reg.has)
                begin
                    if (frm_reg.created >= BLOBS_C)
                    begin
                        f.ovf  = 1'b1;
                        stored = 1'b0;
                    end
                    else
                    begin
                        cv        = frm_reg.created[BLOB_W-1:0];
                        f.created = frm_reg.created + BCNT_W'(1);
                        par_we    = 1'b1;
                        par_waddr = cv;
                        par_wdata = cv;
                        nr.rank   = '0;
                        nr.left   = clo_reg.cstart;
                        nr.right  = clo_reg.cstop;
                        nr.bottom = clo_reg.y;
                        nr.top    = clo_reg.y;
                        nr.area   = AREA_W'(len_s);
                        nr.csum   = SUM_W'(clo_reg.csum);
                        nr.rsum   = prod_reg;
                        rec_we    = 1'b1;
                        rec_waddr = cv;
                        rec_wdata = nr;
                    end
                end
                if (stored)
                begin
                    if (frm_reg.cur_cnt >= RUNS_C)
                    begin
                        f.ovf = 1'b1;
                    end
                    else
                    begin
                        run_we    = 1'b1;
                        run_wdata = '{rstart: clo_reg.cstart, rstop: clo_reg.cstop, blob: cv};
                        f.cur_cnt = frm_reg.cur_cnt + RCNT_W'(1);
                    end
                end
                if (clo_reg.eol)
                begin
                    f = row_end(f, eff_h);
                end
                state_next = S_IDLE;
            end

            S_RD_SCAN:
            begin
                if (k_reg >= frm_reg.created)
                begin
                    res_next               = '0;
                    res_next.pool_overflow = frm_reg.ovf;
                    f.readout              = frm_reg.created;
                    state_next             = S_OUT;
                end
                else
                begin
                    par_re     = 1'b1;
                    par_raddr  = k_reg[BLOB_W-1:0];
                    state_next = S_RD_CHK;
                end
            end

            S_RD_CHK:
            begin
                if (par_rdata == k_reg[BLOB_W-1:0])
                begin
                    rec_re     = 1'b1;
                    rec_raddr  = k_reg[BLOB_W-1:0];
                    nxt_next   = k_reg + BCNT_W'(1);
                    state_next = S_RD_NXT;
                end
                else
                begin
                    k_next     = k_reg + BCNT_W'(1);
                    state_next = S_RD_SCAN;
                end
            end

            S_RD_NXT:
            begin
                if (nxt_reg >= frm_reg.created)
                begin
                    last_next  = 1'b1;
                    state_next = S_DIV_LD;
                end
                else
                begin
                    par_re     = 1'b1;
                    par_raddr  = nxt_reg[BLOB_W-1:0];
                    state_next = S_RD_NCHK;
                end
            end

            S_RD_NCHK:
            begin
                if (par_rdata == nxt_reg[BLOB_W-1:0])
                begin
                    last_next  = 1'b0;
                    state_next = S_DIV_LD;
                end
                else
                begin
                    nxt_next   = nxt_reg + BCNT_W'(1);
                    state_next = S_RD_NXT;
                end
            end

            S_DIV_LD:
            begin
                res_next.blob_valid    = 1'b1;
                res_next.box_left      = rec_rdata.left;
                res_next.box_top       = COL_W'(eff_h - DIM_W'(1) - {1'b0, rec_rdata.top});
                res_next.box_right     = rec_rdata.right;
                res_next.box_bottom    = COL_W'(eff_h - DIM_W'(1) - {1'b0, rec_rdata.bottom});
                res_next.blob_area     = rec_rdata.area;
                res_next.centroid_col  = '0;
                res_next.centroid_row  = '0;
                res_next.end_of_list   = last_reg;
                res_next.pool_overflow = frm_reg.ovf;
                f.readout              = k_reg + BCNT_W'(1);
                div_d_next             = rec_rdata.area;
                div_q_next             = rec_rdata.csum;
                div_rem_next           = '0;
                div_cnt_next           = '0;
                div_y_next             = 1'b0;
                state_next             = S_DIV;
            end

            S_DIV:
            begin
                if (rsh >= {1'b0, div_d_reg})
                begin
                    div_rem_next = AREA_W'(rsh - {1'b0, div_d_reg});
                    qn           = {div_q_reg[SUM_W-2:0], 1'b1};
                end
                else
                begin
                    div_rem_next = rsh[AREA_W-1:0];
                    qn           = {div_q_reg[SUM_W-2:0], 1'b0};
                end
                div_q_next   = qn;
                div_cnt_next = div_cnt_reg + DIV_CW'(1);
                if (div_cnt_reg == DIV_CW'(SUM_W - 1))
                begin
                    if (!div_y_reg)
                    begin
                        res_next.centroid_col = (div_d_reg == '0) ? '0 : qn[COL_W-1:0];
                        div_q_next            = rec_rdata.rsum;
                        div_rem_next          = '0;
                        div_cnt_next          = '0;
                        div_y_next            = 1'b1;
                    end
                    else
                    begin
                        res_next.centroid_row = (div_d_reg == '0) ? '0 : qn[COL_W-1:0];
                        state_next            = S_OUT;
                    end
                end
            end

            S_OUT:
            begin
                if (!out_valid_reg)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        frm_next = f;
        clo_next = c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            frm_reg       <= '0;
            out_valid_reg <= 1'b0;
            width_reg     <= MAX_W_C;
            height_reg    <= MAX_H_C;
            wob_reg       <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            frm_reg       <= frm_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr)
            begin
                unique case (paddr[3:2])
                    REG_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
                    REG_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
                    REG_WOB:    wob_reg    <= pwdata[0];
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        clo_reg     <= clo_next;
        out_reg     <= out_next;
        res_reg     <= res_next;
        arec_reg    <= arec_next;
        prod_reg    <= prod_next;
        k_reg       <= k_next;
        nxt_reg     <= nxt_next;
        last_reg    <= last_next;
        div_rem_reg <= div_rem_next;
        div_d_reg   <= div_d_next;
        div_q_reg   <= div_q_next;
        div_cnt_reg <= div_cnt_next;
        div_y_reg   <= div_y_next;
    end

    a_prev_bound: assert property (@(posedge clk) disable iff (!rst_n)
        frm_reg.prev_cnt <= RUNS_C && frm_reg.cur_cnt <= RUNS_C)
        else $error("run count beyond run store");

    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        frm_reg.created <= BLOBS_C && frm_reg.readout <= frm_reg.created)
        else $error("blob pool or readout position out of range");

    a_merge_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MRG_B |-> clo_reg.cur != clo_reg.node)
        else $error("merge of a root with itself");

    a_area_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) && out_reg.blob_valid |-> out_reg.blob_area != '0)
        else $error("blob record with empty area");

    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |=> state_reg != S_RD_SCAN || $past(state_reg) == S_IDLE
            || $past(state_reg) == S_RD_CHK)
        else $error("readout scan entered from an unexpected state");

endmodule

### sv/rbba_ram.sv
module rbba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top
    import rbba_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int SETTLE_CYCLES  = 5000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    pix_in_t   in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    blob_out_t out_data;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    run_based_blob_analysis_core uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // blob labelling predictor state
    int unsigned cfg_w = 1024, cfg_h = 1024, cfg_wob = 1;
    int unsigned col_pos, row_pos, span_beg, span_acc;
    bit          span_on, frame_end;
    int unsigned span_lo [2][MAX_RUNS_PER_ROW];
    int unsigned span_hi [2][MAX_RUNS_PER_ROW];
    int unsigned span_id [2][MAX_RUNS_PER_ROW];
    int unsigned prev_spans, cur_spans, bank;
    int unsigned parent [MAX_BLOBS];
    int unsigned rank_of [MAX_BLOBS];
    int unsigned bx_left [MAX_BLOBS];
    int unsigned bx_bot [MAX_BLOBS];
    int unsigned bx_right [MAX_BLOBS];
    int unsigned bx_top [MAX_BLOBS];
    int unsigned area [MAX_BLOBS];
    int unsigned col_sum [MAX_BLOBS];
    int unsigned row_sum [MAX_BLOBS];
    int unsigned blob_count, read_pos;
    bit          pool_full;

    pix_in_t     pixel_q[$];
    blob_out_t   blob_q[$];
    int unsigned errors = 0;
    int unsigned in_gap = 0;
    int unsigned out_stall = 0;
    int unsigned idle_cycles = 0;
    bit          in_burst = 1'b0;
    bit          out_burst = 1'b0;
    bit          in_busy;

    function automatic int unsigned eff_w();
        return (cfg_w < 1) ? 1 : (cfg_w > MAX_WIDTH) ? MAX_WIDTH : cfg_w;
    endfunction

    function automatic int unsigned eff_h();
        return (cfg_h < 1) ? 1 : (cfg_h > MAX_HEIGHT) ? MAX_HEIGHT : cfg_h;
    endfunction

    function automatic int unsigned clip(int unsigned i);
        return (i < MAX_BLOBS) ? i : 0;
    endfunction

    function automatic int unsigned root_of(int unsigned i);
        int unsigned r, c, n, nx;
        r = clip(i);
        c = clip(i);
        n = 0;
        while (parent[r] != r && n < MAX_BLOBS)
        begin
            r = clip(parent[r]);
            n++;
        end
        n = 0;
        while (c != r && n < MAX_BLOBS)
        begin
            nx = clip(parent[c]);
            parent[c] = r;
            c = nx;
            n++;
        end
        return r;
    endfunction

    function automatic int unsigned join_blobs(int unsigned a, int unsigned b);
        int unsigned ra, rb, r, nl, nbt, nr, nt, ar, sx, sy;
        ra = root_of(a);
        rb = root_of(b);
        nl  = (bx_left[ra] < bx_left[rb]) ? bx_left[ra] : bx_left[rb];
        nbt = (bx_bot[ra] < bx_bot[rb]) ? bx_bot[ra] : bx_bot[rb];
        nr  = (bx_right[ra] > bx_right[rb]) ? bx_right[ra] : bx_right[rb];
        nt  = (bx_top[ra] > bx_top[rb]) ? bx_top[ra] : bx_top[rb];
        ar = area[ra] + area[rb];
        sx = col_sum[ra] + col_sum[rb];
        sy = row_sum[ra] + row_sum[rb];
        if (rank_of[ra] > rank_of[rb])
        begin
            parent[rb] = ra;
            r = ra;
        end
        else
        begin
            parent[ra] = rb;
            if (rank_of[ra] == rank_of[rb] && rank_of[rb] < RANK_MAX)
                rank_of[rb]++;
            r = rb;
        end
        bx_left[r] = nl;
        bx_bot[r] = nbt;
        bx_right[r] = nr;
        bx_top[r] = nt;
        area[r] = ar;
        col_sum[r] = sx;
        row_sum[r] = sy;
        return r;
    endfunction

    function automatic void close_span(int unsigned s, int unsigned e, int unsigned sum);
        int unsigned y, len, flip, pb, lb, cur;
        bit          hit;
        y = row_pos;
        len = e - s + 1;
        flip = (eff_h() - 1) - y;
        pb = bank ^ 1;
        cur = 0;
        hit = 1'b0;
        for (int unsigned i = 0; i < prev_spans && i < MAX_RUNS_PER_ROW; i++)
        begin
            lb = root_of(span_id[pb][i]);
            if (e + 1 >= span_lo[pb][i] && s <= span_hi[pb][i] + 1)
            begin
                if (!hit)
                begin
                    hit = 1'b1;
                    cur = lb;
                    if (s < bx_left[lb]) bx_left[lb] = s;
                    if (e > bx_right[lb]) bx_right[lb] = e;
                    bx_top[lb] = y;
                    area[lb] += len;
                    col_sum[lb] += sum;
                    row_sum[lb] += flip * len;
                end
                else if (cur != lb)
                begin
                    cur = join_blobs(cur, lb);
                end
            end
        end
        if (!hit)
        begin
            if (blob_count >= MAX_BLOBS)
            begin
                pool_full = 1'b1;
                return;
            end
            cur = blob_count++;
            parent[cur] = cur;
            rank_of[cur] = 0;
            bx_left[cur] = s;
            bx_right[cur] = e;
            bx_bot[cur] = y;
            bx_top[cur] = y;
            area[cur] = len;
            col_sum[cur] = sum;
            row_sum[cur] = flip * len;
        end
        if (cur_spans >= MAX_RUNS_PER_ROW)
        begin
            pool_full = 1'b1;
            return;
        end
        span_lo[bank][cur_spans] = s;
        span_hi[bank][cur_spans] = e;
        span_id[bank][cur_spans] = cur;
        cur_spans++;
    endfunction

    function automatic void new_frame();
        col_pos = 0;
        row_pos = 0;
        span_beg = 0;
        span_acc = 0;
        span_on = 1'b0;
        prev_spans = 0;
        cur_spans = 0;
        bank = 0;
        blob_count = 0;
        read_pos = 0;
        pool_full = 1'b0;
        frame_end = 1'b0;
    endfunction

    function automatic void predict_blobs(pix_in_t it);
        int unsigned w, x, bg, k, nxt, h1, a;
        bit          fg;
        blob_out_t   r;
        if (it.action == ACT_PIXEL)
        begin
            w = eff_w();
            bg = cfg_wob ? 0 : 1;
            fg = (it.pixel != bg);
            if (frame_end) new_frame();
            x = col_pos;
            if (fg)
            begin
                if (!span_on)
                begin
                    span_on = 1'b1;
                    span_beg = x;
                    span_acc = 0;
                end
                span_acc += x;
                if (x + 1 >= w)
                begin
                    span_on = 1'b0;
                    close_span(span_beg, x, span_acc);
                end
            end
            else if (span_on)
            begin
                span_on = 1'b0;
                close_span(span_beg, x - 1, span_acc);
            end
            col_pos = x + 1;
            if (col_pos >= w)
            begin
                col_pos = 0;
                bank ^= 1;
                prev_spans = cur_spans;
                cur_spans = 0;
                row_pos++;
                if (row_pos >= eff_h())
                begin
                    frame_end = 1'b1;
                    row_pos = 0;
                    prev_spans = 0;
                end
            end
            return;
        end
        r = '0;
        r.pool_overflow = pool_full;
        k = read_pos;
        while (k < blob_count && k < MAX_BLOBS && parent[k] != k) k++;
        if (k >= blob_count || k >= MAX_BLOBS)
        begin
            read_pos = blob_count;
            blob_q.push_back(r);
            return;
        end
        nxt = k + 1;
        while (nxt < blob_count && nxt < MAX_BLOBS && parent[nxt] != nxt) nxt++;
        h1 = eff_h() - 1;
        a = area[k];
        r.blob_valid = 1'b1;
        r.box_left = COL_W'(bx_left[k]);
        r.box_top = COL_W'(h1 - bx_top[k]);
        r.box_right = COL_W'(bx_right[k]);
        r.box_bottom = COL_W'(h1 - bx_bot[k]);
        r.blob_area = AREA_W'(a);
        r.centroid_col = (a != 0) ? COL_W'(col_sum[k] / a) : '0;
        r.centroid_row = (a != 0) ? COL_W'(row_sum[k] / a) : '0;
        r.end_of_list = (nxt >= blob_count || nxt >= MAX_BLOBS);
        read_pos = k + 1;
        blob_q.push_back(r);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_busy = in_valid;
            if (in_valid && in_ready)
            begin
                predict_blobs(in_data);
                in_busy = 1'b0;
            end
            if (!in_busy)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                end
                else if (pixel_q.size() > 0)
                begin
                    in_data <= pixel_q.pop_front();
                    in_busy = 1'b1;
                    in_gap = in_burst ? 0 : $urandom_range(0, 8);
                end
            end
            in_valid <= in_busy;
        end
    end

    always @(posedge clk)
    begin
        blob_out_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (blob_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected transfer: %p", out_data);
                end
                else
                begin
                    want = blob_q.pop_front();
                    if (out_data !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected %p got %p", want, out_data);
                    end
                end
                out_stall = out_burst ? 0 : $urandom_range(0, 8);
            end
            else if (out_stall > 0)
            begin
                out_stall--;
            end
            out_ready <= (out_stall == 0);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)
                || (pixel_q.size() == 0 && !in_valid && blob_q.size() == 0))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[run_based_blob_analysis_core] ERROR");
            $finish;
        end
    end

    task automatic write_reg(reg_idx_t idx, int unsigned value);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= PADDR_W'(4 * idx);
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_WIDTH:  cfg_w = value & 'h7FF;
            REG_HEIGHT: cfg_h = value & 'h7FF;
            default:    cfg_wob = value & 1;
        endcase
    endtask

    task automatic drain();
        do @(posedge clk);
        while (pixel_q.size() != 0 || in_valid || blob_q.size() != 0 || !in_ready);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(int unsigned w, int unsigned h, int unsigned wob);
        drain();
        in_burst = ($urandom_range(0, 3) == 0);
        out_burst = ($urandom_range(0, 3) == 0);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_WOB, wob);
    endtask

    function automatic void push_item(action_t act, logic [7:0] value);
        pix_in_t it;
        it.action = act;
        it.pixel = value;
        pixel_q.push_back(it);
    endfunction

    function automatic void push_reads(int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            push_item(ACT_READ, 8'($urandom_range(0, 255)));
    endfunction

    function automatic void random_phase(int unsigned n);
        int unsigned w, h, bg, frame_px, cnt;
        logic [7:0]  v;
        bit          fg;
        w = eff_w();
        h = eff_h();
        frame_px = w * h;
        bg = cfg_wob ? 0 : 1;
        fg = 1'b0;
        cnt = 0;
        for (int unsigned i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                push_reads(1);
                continue;
            end
            if ($urandom_range(0, 3) == 0) fg = !fg;
            v = 8'($urandom_range(0, 255));
            if (!fg) v = 8'(bg);
            else if (v == bg) v = 8'(bg) ^ 8'h80;
            push_item(ACT_PIXEL, v);
            cnt++;
            if (cnt == frame_px)
            begin
                cnt = 0;
                push_reads($urandom_range(1, 6));
            end
        end
    endfunction

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reads on an empty pool, then a 4x3 frame with a diagonal merge
        push_reads(2);
        configure(4, 3, 1);
        push_item(ACT_PIXEL, 8'h01);
        push_item(ACT_PIXEL, 8'h00);
        push_item(ACT_PIXEL, 8'h00);
        push_item(ACT_PIXEL, 8'hFF);
        push_item(ACT_PIXEL, 8'h00);
        push_item(ACT_PIXEL, 8'h80);
        push_item(ACT_PIXEL, 8'h7F);
        push_item(ACT_PIXEL, 8'h00);
        push_reads(1);
        push_item(ACT_PIXEL, 8'h00);
        push_item(ACT_PIXEL, 8'h00);
        push_item(ACT_PIXEL, 8'h00);
        push_item(ACT_PIXEL, 8'h55);
        push_reads(3);
        push_item(ACT_PIXEL, 8'hAA);
        push_item(ACT_PIXEL, 8'h00);
        push_reads(2);

        configure(7, 5, 1);
        random_phase(130);
        configure(16, 8, 0);
        random_phase(130);
        configure(1, 30, 1);
        random_phase(110);
        configure(2047, 0, 0);
        random_phase(130);
        configure(0, 2047, 1);
        random_phase(130);
        configure(5, 9, 1);
        random_phase(110);
        configure(3, 3, 0);
        random_phase(130);
        configure(1024, 1024, 1);
        random_phase(100);

        drain();
        if (errors == 0 && blob_q.size() == 0)
            $display("[run_based_blob_analysis_core] OK");
        else
            $display("[run_based_blob_analysis_core] ERROR");
        $finish;
    end

endmodule

### files.f
sv/rbba_pkg.sv
sv/rbba_ram.sv
sv/run_based_blob_analysis_core.sv
verif/tb_top.sv
